[rtl/ssm_pkg.sv]
package ssm_pkg;

    localparam int CHAR_W      = 8;
    localparam int PATTERN_W   = 64;
    localparam int PLEN_W      = 4;
    localparam int POS_W       = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    // one text byte on its way from the front queue to the matcher
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } ssm_item_t;

endpackage

[rtl/ssm_front.sv]
module ssm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ssm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                q_valid,
    input  logic                                q_ready,
    output ssm_pkg::ssm_item_t                  q_item
);
    import ssm_pkg::*;

    localparam int DEPTH = 2;

    ssm_item_t   slot_reg [DEPTH];
    logic [1:0]  fill_reg, fill_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic        push;
    logic        pop;
    ssm_item_t   in_item;

    assign in_item.text_char = s_axis_tdata[CHAR_W-1:0];
    assign in_item.last_char = s_axis_tlast;

    assign s_axis_tready = (fill_reg != 2'(DEPTH));
    assign q_valid       = (fill_reg != 2'd0);
    assign q_item        = slot_reg[rd_ptr_reg];

    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = q_valid && q_ready;

    always_comb
    begin
        fill_next   = fill_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/ssm_back.sv]
module ssm_back #(
    parameter int PATTERN_MAX = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ssm_pkg::PATTERN_W-1:0]       pattern_bytes,
    input  logic [ssm_pkg::PLEN_W-1:0]          pattern_length,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  ssm_pkg::ssm_item_t                  q_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_found,
    output logic [ssm_pkg::POS_W-1:0]           out_position
);
    import ssm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [CHAR_W-1:0]     win_reg  [PATTERN_MAX];
    logic [CHAR_W-1:0]     win_next [PATTERN_MAX];
    logic [CHAR_W-1:0]     win_shift [PATTERN_MAX];
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  seen_reg, seen_next;
    logic [COUNT_BITS-1:0] start_reg, start_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg, found_next;
    logic [POS_W-1:0]      position_reg, position_next;

    logic [LEN_W-1:0]      len;
    logic [PATTERN_MAX:0]  len_hit;
    logic                  window_hit;
    logic                  pop;
    logic                  step_seen;
    logic [COUNT_BITS-1:0] step_start;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] len_ext;

    // clamp lengths beyond the window
    assign len = (pattern_length > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                         : LEN_W'(pattern_length);
    assign len_ext = COUNT_BITS'(len);

    // shift the new byte into the newest slot
    always_comb
    begin
        win_shift[0] = q_item.text_char;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_shift[k] = win_reg[k-1];
        end
    end

    // one comparator group per candidate length; pick by the active one
    assign len_hit[0] = 1'b0;
    for (genvar gl = 1; gl <= PATTERN_MAX; gl++)
    begin : g_len
        logic [gl-1:0] eq;
        for (genvar gj = 0; gj < gl; gj++)
        begin : g_chr
            assign eq[gj] = (win_shift[gl-1-gj] == pattern_bytes[CHAR_W*gj +: CHAR_W]);
        end
        assign len_hit[gl] = &eq;
    end
    assign window_hit = len_hit[len];

    assign q_ready = !q_item.last_char || !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        step_seen  = seen_reg;
        step_start = start_reg;
        count_next = count_reg;
        // a saturated count stops comparing
        if (count_reg != '1)
        begin
            count_next = count_inc;
            if ((len != '0) && !seen_reg && (count_inc >= len_ext) && window_hit)
            begin
                step_seen  = 1'b1;
                step_start = count_inc - len_ext;
            end
        end
    end

    always_comb
    begin
        win_next       = win_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        position_next  = position_reg;
        if (pop)
        begin
            if (q_item.last_char)
            begin
                out_valid_next = 1'b1;
                if (len == '0)
                begin
                    found_next    = 1'b1;
                    position_next = '0;
                end
                else
                begin
                    found_next    = step_seen;
                    position_next = step_seen ? POS_W'(step_start) : '0;
                end
                // drop the stream state for the next text
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    win_next[k] = '0;
                end
                seen_next  = 1'b0;
                start_next = '0;
            end
            else
            begin
                win_next   = win_shift;
                seen_next  = step_seen;
                start_next = step_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                win_reg[k] <= '0;
            end
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            if (pop)
            begin
                count_reg <= q_item.last_char ? '0 : count_next;
            end
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = found_reg;
    assign out_position = position_reg;

endmodule

[rtl/substring_first_match.sv]
// Finds the first place where a pattern of up to PATTERN_MAX bytes occurs in a
// text streamed one byte per item on s_axis, the final byte marked by tlast.
// For each text one result leaves on m_axis after its last byte: found and the
// start index of the first match (zero-length pattern gives found at 0; a
// match ending past the saturated byte count is not reported). Throughput is
// one byte per clock while no last byte waits: a two-entry input queue feeds
// a matcher that shifts the byte into its window and compares every pattern
// length in parallel in the same cycle. The result register loads, and the
// result is offered, at the edge where the last byte leaves the queue. A last
// byte waits at the head of the queue while an earlier result is still
// untaken; the input stalls once both queue entries are full. Write the
// pattern registers only while no text is in flight.
module substring_first_match #(
    parameter int PATTERN_MAX = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssm_pkg::PATTERN_W-1:0]       cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ssm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] text_char
    input  logic                                s_axis_tlast,   // last_char
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ssm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // [0] found, [16:1] position
);
    import ssm_pkg::*;

    logic [PATTERN_W-1:0] pattern_bytes_reg;
    logic [PLEN_W-1:0]    pattern_length_reg;
    logic                 q_valid;
    logic                 q_ready;
    ssm_item_t            q_item;
    logic                 out_found;
    logic [POS_W-1:0]     out_position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_wdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[PLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    ssm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    ssm_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_found      (out_found),
        .out_position   (out_position)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - POS_W - 1)'(0), out_position, out_found};

    // a full queue always offers an item to the matcher
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_valid)
        else $error("input queue full without a head item");

    // a pending result blocks the next last byte
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && q_valid && q_item.last_char) |-> !q_ready)
        else $error("last byte taken while a result is pending");

    // a result only follows a last byte leaving the queue
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(q_valid && q_ready && q_item.last_char))
        else $error("result without a last byte");

endmodule

[tb/sv/tb_substring_first_match.sv]
`timescale 1ns / 100ps

module tb_substring_first_match;

    import ssm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    typedef struct {
        logic              found;
        logic [POS_W-1:0]  position;
    } match_result_t;

    // Tracks the text seen so far and predicts the result of each text.
    class first_match_tracker;
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [PLEN_W-1:0]    pattern_len;
        logic [CHAR_W-1:0]    window [8];
        logic [15:0]          byte_count;
        logic                 seen;
        logic [15:0]          first_start;
        match_result_t        pending_matches [$];
        int                   mismatch_count;

        function new();
            pattern_bytes = '0;
            pattern_len = '0;
            mismatch_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[k])
                window[k] = '0;
            byte_count = '0;
            seen = 1'b0;
            first_start = '0;
        endfunction

        function int active_len();
            return (pattern_len > 8) ? 8 : int'(pattern_len);
        endfunction

        function void note_text_byte(logic [CHAR_W-1:0] c, logic last);
            int eff;
            bit hit;
            match_result_t res;
            eff = active_len();
            for (int k = 7; k > 0; k--)
                window[k] = window[k-1];
            window[0] = c;
            // a byte arriving at the saturated count is shifted in but not compared
            if (byte_count != COUNT_TOP) begin
                byte_count = byte_count + 16'd1;
                if (eff > 0 && !seen && byte_count >= eff) begin
                    hit = 1'b1;
                    for (int j = 0; j < eff; j++)
                        if (window[eff-1-j] != pattern_bytes[8*j +: 8])
                            hit = 1'b0;
                    if (hit) begin
                        seen = 1'b1;
                        first_start = byte_count - 16'(eff);
                    end
                end
            end
            if (last) begin
                if (eff == 0) begin
                    res.found = 1'b1;
                    res.position = '0;
                end
                else begin
                    res.found = seen;
                    res.position = seen ? first_start : '0;
                end
                pending_matches.push_back(res);
                clear_text();
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        task check_match_result(logic [OUT_TDATA_W-1:0] data);
            match_result_t want;
            logic found;
            logic [POS_W-1:0] position;
            found = data[0];
            position = data[16:1];
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("result found=%0d position=%0d with none pending",
                                          found, position));
            end
            else begin
                want = pending_matches.pop_front();
                if (found !== want.found)
                    report_mismatch($sformatf("found %0d, predicted %0d", found, want.found));
                if (position !== want.position)
                    report_mismatch($sformatf("position %0d, predicted %0d",
                                              position, want.position));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PATTERN_W-1:0]   cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] text_char
    logic                   s_axis_tlast;   // last_char
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [0] found, [16:1] position

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    first_match_tracker tracker = new();

    substring_first_match uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_match_result(m_axis_tdata);
    end

    // end the run when no item moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_text_byte(c, last);
    endtask

    task automatic send_text(input logic [CHAR_W-1:0] text [$]);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    // hold off until every predicted result is out and the matcher is quiet
    task automatic wait_until_settled();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pattern(input logic [PATTERN_W-1:0] pat, input logic [PLEN_W-1:0] len);
        wait_until_settled();
        cfg_we <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_wdata <= pat;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_wdata <= PATTERN_W'(len);
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.pattern_bytes = pat;
        tracker.pattern_len = len;
    endtask

    task automatic send_random_text(output int len);
        logic [CHAR_W-1:0] text [$];
        logic [CHAR_W-1:0] other;
        int eff, mode, r, at, j;
        eff = tracker.active_len();
        other = CHAR_W'($urandom_range(255));
        mode = $urandom_range(9);
        r = $urandom_range(19);
        if (r < 14)
            len = $urandom_range(12, 1);
        else if (r < 19)
            len = $urandom_range(40, 13);
        else
            len = $urandom_range(90, 41);
        for (int i = 0; i < len; i++) begin
            j = (eff > 0) ? $urandom_range(eff - 1) : 0;
            if (mode < 2 || eff == 0)
                text.push_back(CHAR_W'($urandom_range(255)));
            else if ($urandom_range(3) == 0)
                text.push_back(other);
            else
                text.push_back(tracker.pattern_bytes[8*j +: 8]);
        end
        // plant the pattern; in one mode spoil its final character
        if (mode >= 5 && eff > 0 && len >= eff) begin
            at = $urandom_range(len - eff);
            for (int k = 0; k < eff; k++)
                text[at+k] = tracker.pattern_bytes[8*k +: 8];
            if (mode == 5)
                text[at+eff-1] = ~text[at+eff-1];
        end
        send_text(text);
    endtask

    initial
    begin
        logic [PATTERN_W-1:0] pat;
        logic [PLEN_W-1:0] plen;
        logic [CHAR_W-1:0] a, b;
        int setting, sent, len, kind;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length pattern straight after reset
        send_text('{8'h5A});
        // cleared window must not pass for a run of zero characters
        set_pattern(64'h0, 4'd2);
        send_text('{8'h00});
        // text shorter than the pattern, then a match at index 1
        set_pattern(64'h00FF00, 4'd3);
        send_text('{8'h00, 8'hFF});
        send_text('{8'hFF, 8'h00, 8'hFF, 8'h00});
        set_pattern({PATTERN_W{1'b1}}, 4'd8);
        send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        // oversize length acts as the full eight characters
        set_pattern({PATTERN_W{1'b1}}, 4'd15);
        send_text('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

        setting = 0;
        for (int phase = 0; phase < 4; phase++) begin
            for (int s = 0; s < 4; s++) begin
                kind = $urandom_range(2);
                a = CHAR_W'($urandom_range(255));
                b = CHAR_W'($urandom_range(255));
                for (int j = 0; j < 8; j++)
                    pat[8*j +: 8] = (kind == 0) ? CHAR_W'($urandom_range(255))
                                                : ($urandom_range(1) ? a : b);
                r_len: begin
                    int r;
                    r = $urandom_range(9);
                    if (r < 7)
                        plen = PLEN_W'($urandom_range(8, 1));
                    else if (r == 7)
                        plen = 4'd0;
                    else
                        plen = PLEN_W'($urandom_range(15, 9));
                end
                case (setting)
                    0: begin pat = '0; plen = 4'd8; end
                    1: begin pat = {PATTERN_W{1'b1}}; plen = 4'd15; end
                    2: plen = 4'd0;
                    3: plen = 4'd1;
                    default: ;
                endcase
                set_pattern(pat, plen);
                case (phase)
                    0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                    1: begin sender_idle_pct = 47; stall_pct = 0;  end
                    2: begin sender_idle_pct = 0;  stall_pct = 47; end
                    default: begin sender_idle_pct = 6; stall_pct = 6; end
                endcase
                sent = 0;
                while (sent < 82) begin
                    send_random_text(len);
                    sent += len;
                end
                setting++;
            end
        end

        wait_until_settled();
        if (tracker.mismatch_count == 0 && tracker.pending_matches.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
